// ----- rtl/core/windowed_ssim_map_unit_defines.svh -----
// Assertion macros used by the checker file of the SSIM map unit.
`ifndef WINDOWED_SSIM_MAP_UNIT_DEFINES_SVH
`define WINDOWED_SSIM_MAP_UNIT_DEFINES_SVH

// Same-cycle implication, quiet while reset is high.
`define WSM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, quiet while reset is high.
`define WSM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/wsm_pkg.sv -----
// ----------------------------------------------------------------------------
// wsm_pkg
// Shared types, sizes and constants of the windowed SSIM map unit.
// ----------------------------------------------------------------------------
`default_nettype none

package wsm_pkg;

  localparam int MAX_WIDTH = 1024;
  localparam int CIDX_W    = $clog2(MAX_WIDTH);
  localparam int ADDR_W    = CIDX_W + 2;
  localparam int LS_DEPTH  = 4 * MAX_WIDTH;
  localparam int WIN_N     = 25;

  localparam int DIV_W = 53;
  localparam int Q_W   = 31;

  localparam logic [DIV_W-1:0] C1_SCALED = DIV_W'(65025);
  localparam logic [DIV_W-1:0] C2_SCALED = DIV_W'(64'd38353305600);

  typedef enum logic [2:0] {
    REG_LINE_WIDTH   = 3'd0,
    REG_FRAME_HEIGHT = 3'd1,
    REG_WEIGHT_D0    = 3'd2,
    REG_WEIGHT_D1    = 3'd3,
    REG_WEIGHT_D2    = 3'd4,
    REG_WEIGHT_D4    = 3'd5,
    REG_WEIGHT_D5    = 3'd6,
    REG_WEIGHT_D8    = 3'd7
  } reg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_READ,
    S_WRITE,
    S_SHIFT,
    S_SUM,
    S_DEV,
    S_MEANS,
    S_PREP,
    S_ABS,
    S_DSTART,
    S_DIV,
    S_MUL,
    S_ROUND,
    S_OUT
  } state_t;

  typedef struct packed {
    logic en;
    logic take_ext;
  } cell_ctrl_t;

  // weight slot for each window position, by squared distance 0,1,2,4,5,8
  localparam logic [2:0] WSLOT [WIN_N] = '{
    3'd5, 3'd4, 3'd3, 3'd4, 3'd5,
    3'd4, 3'd2, 3'd1, 3'd2, 3'd4,
    3'd3, 3'd1, 3'd0, 3'd1, 3'd3,
    3'd4, 3'd2, 3'd1, 3'd2, 3'd4,
    3'd5, 3'd4, 3'd3, 3'd4, 3'd5
  };

endpackage

`default_nettype wire

// ----- rtl/core/wsm_ram.sv -----
// ----------------------------------------------------------------------------
// wsm_ram
// Generic simple dual-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module wsm_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/wsm_cell.sv -----
// ----------------------------------------------------------------------------
// wsm_cell
// One window cell: holds a pixel pair, loads from its neighbor or the new column.
// ----------------------------------------------------------------------------
`default_nettype none

module wsm_cell (
  input  wire logic                clk,
  input  wire wsm_pkg::cell_ctrl_t ctrl,
  input  wire logic [15:0]         nbr,
  input  wire logic [15:0]         ext,
  output logic      [15:0]         pair
);

  import wsm_pkg::*;

  always_ff @(posedge clk) begin
    if (ctrl.en) begin
      pair <= ctrl.take_ext ? ext : nbr;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/wsm_frac.sv -----
// ----------------------------------------------------------------------------
// wsm_frac
// Restoring divider: floor(num * 2^30 / den) for num <= den, one bit a cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module wsm_frac (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      start,
  input  wire logic [wsm_pkg::DIV_W-1:0] num,
  input  wire logic [wsm_pkg::DIV_W-1:0] den,
  output logic      [wsm_pkg::Q_W-1:0]   q,
  output logic                           busy
);

  import wsm_pkg::*;

  logic [DIV_W-1:0] rem;
  logic [DIV_W-1:0] dsr;
  logic [4:0]       cnt;
  logic [DIV_W:0]   trial;
  logic             ge;

  // first step compares the numerator itself, later steps shift in a zero
  always_comb begin
    trial = (cnt == 5'd0) ? {1'b0, rem} : {rem, 1'b0};
    ge    = trial >= {1'b0, dsr};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= '0;
      rem  <= num;
      dsr  <= den;
      q    <= '0;
    end else if (busy) begin
      rem <= ge ? DIV_W'(trial - {1'b0, dsr}) : trial[DIV_W-1:0];
      q   <= {q[Q_W-2:0], ge};
      cnt <= cnt + 5'd1;
      if (cnt == 5'(Q_W - 1)) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/windowed_ssim_map_unit.sv -----
// ----------------------------------------------------------------------------
// windowed_ssim_map_unit
// Streaming 5x5 SSIM map over two gray images, signed Q2.14 output.
// ----------------------------------------------------------------------------
// Usage: pixel pairs enter in raster order on the input channel (in_valid,
// in_ready, pixel_a, pixel_b). Each pixel whose row and column are both at
// least 4 yields one beat on the output channel (out_valid, out_ready,
// ssim_value, last_of_frame) for the window centre two rows up and two
// columns left; last_of_frame marks the final beat of the frame.
// One item is worked at a time. An item without a result occupies the block
// for four line store reads, one line store write, then a window shift. An
// item with a result goes on to its output beat: the 25-cell window chain
// rotates twice (sums, then weighted deviations), then two 31-step dividers
// produce the two ratios side by side.
// The output beat sits in its own register, so a stalled receiver does not
// block the next item until that item's result is ready to be loaded.
// Reset clears counters, control and configuration to defaults; the line
// stores are not cleared. Configuration is an APB-style port, pready tied high.
// ----------------------------------------------------------------------------
`default_nettype none

module windowed_ssim_map_unit (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [4:0]        paddr,
  input  wire logic [31:0]       pwdata,
  output logic      [31:0]       prdata,
  output logic                   pready,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire logic [7:0]        pixel_a,
  input  wire logic [7:0]        pixel_b,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic signed [15:0]     ssim_value,
  output logic                   last_of_frame
);

  import wsm_pkg::*;

  localparam logic [12:0] MAX_W13 = 13'(MAX_WIDTH);

  // configuration
  logic [10:0] line_width;
  logic [12:0] frame_height;
  logic [15:0] weight [6];

  // position counters
  logic [10:0] column_count;
  logic [12:0] row_count;

  // item registers
  logic [7:0]        pix_a, pix_b;
  logic [1:0]        row2;
  logic [CIDX_W-1:0] col_q;
  logic              emit_q;
  logic              last_q;

  state_t state, state_next;
  logic [4:0] k;
  logic [1:0] rcnt;
  logic [1:0] rd_tag;
  logic       rd_pend;
  logic [15:0] col_new [4];
  logic [15:0] new_pair [5];

  // line store
  logic              ls_we, ls_re;
  logic [ADDR_W-1:0] ls_waddr, ls_raddr;
  logic [15:0]       ls_rdata;

  // window chain
  cell_ctrl_t  cctrl [WIN_N];
  logic [15:0] pairs [WIN_N];

  // arithmetic
  logic [12:0]        sx, sy;
  logic [12:0]        a25, b25;
  logic               v1, v2, v3;
  logic signed [13:0] dx, dy;
  logic [15:0]        w1, w2;
  logic signed [27:0] pxx, pyy, pxy;
  logic [41:0]        txx, tyy;
  logic signed [44:0] txy;
  logic [46:0]        fxx, fyy;
  logic signed [47:0] fxy;
  logic [25:0]        pss, psx, psy;
  logic [DIV_W-1:0]   n1, d1, d2, mag2;
  logic signed [53:0] n2;
  logic               neg;
  logic               div_start;
  logic [Q_W-1:0]     q1, q2;
  logic               busy1, busy2;
  logic [61:0]        prod, rsum;
  logic [15:0]        mag16;
  logic signed [16:0] val17;
  logic signed [15:0] res16;

  // size clamps and item flags
  logic [12:0]       lw_c, fh_c;
  logic              end_row, end_frame, emit;
  logic [CIDX_W-1:0] col_idx;
  logic              in_acc, cfg_wr;
  reg_idx_t          cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width   <= 11'd640;
      frame_height <= 13'd480;
      weight[0]    <= 16'd2798;
      weight[1]    <= 16'd2753;
      weight[2]    <= 16'd2707;
      weight[3]    <= 16'd2619;
      weight[4]    <= 16'd2576;
      weight[5]    <= 16'd2452;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LINE_WIDTH:   line_width   <= pwdata[10:0];
        REG_FRAME_HEIGHT: frame_height <= pwdata[12:0];
        REG_WEIGHT_D0:    weight[0]    <= pwdata[15:0];
        REG_WEIGHT_D1:    weight[1]    <= pwdata[15:0];
        REG_WEIGHT_D2:    weight[2]    <= pwdata[15:0];
        REG_WEIGHT_D4:    weight[3]    <= pwdata[15:0];
        REG_WEIGHT_D5:    weight[4]    <= pwdata[15:0];
        REG_WEIGHT_D8:    weight[5]    <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LINE_WIDTH:   prdata = {21'd0, line_width};
      REG_FRAME_HEIGHT: prdata = {19'd0, frame_height};
      REG_WEIGHT_D0:    prdata = {16'd0, weight[0]};
      REG_WEIGHT_D1:    prdata = {16'd0, weight[1]};
      REG_WEIGHT_D2:    prdata = {16'd0, weight[2]};
      REG_WEIGHT_D4:    prdata = {16'd0, weight[3]};
      REG_WEIGHT_D5:    prdata = {16'd0, weight[4]};
      REG_WEIGHT_D8:    prdata = {16'd0, weight[5]};
      default:          prdata = '0;
    endcase
  end

  // clamp sizes; decide row/frame wrap and whether this pixel completes a window
  always_comb begin
    if (line_width < 11'd5) begin
      lw_c = 13'd5;
    end else if ({2'b00, line_width} > MAX_W13) begin
      lw_c = MAX_W13;
    end else begin
      lw_c = {2'b00, line_width};
    end
    if (frame_height < 13'd5) begin
      fh_c = 13'd5;
    end else if (frame_height > 13'd4096) begin
      fh_c = 13'd4096;
    end else begin
      fh_c = frame_height;
    end
    end_row   = {2'b00, column_count} >= (lw_c - 13'd1);
    end_frame = row_count >= (fh_c - 13'd1);
    emit      = (row_count >= 13'd4) && (column_count >= 11'd4);
    if ({2'b00, column_count} < MAX_W13) begin
      col_idx = CIDX_W'(column_count);
    end else begin
      col_idx = CIDX_W'(MAX_WIDTH - 1);
    end
  end

  assign in_ready = (state == S_IDLE);
  assign in_acc   = in_valid & in_ready;

  // latch the beat and advance the raster position
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_acc) begin
      if (end_row) begin
        column_count <= '0;
        row_count    <= end_frame ? 13'd0 : row_count + 13'd1;
      end else begin
        column_count <= column_count + 11'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pix_a  <= pixel_a;
      pix_b  <= pixel_b;
      row2   <= row_count[1:0];
      col_q  <= col_idx;
      emit_q <= emit;
      last_q <= end_row & end_frame;
    end
  end

  // line store: four reads, oldest row first, then write the new pair over the oldest row
  assign ls_re    = (state == S_READ);
  assign ls_raddr = {row2 + rcnt, col_q};
  assign ls_we    = (state == S_WRITE);
  assign ls_waddr = {row2, col_q};

  wsm_ram #(.WIDTH(16), .DEPTH(LS_DEPTH)) u_line_store (
    .clk   (clk),
    .we    (ls_we),
    .waddr (ls_waddr),
    .wdata ({pix_a, pix_b}),
    .re    (ls_re),
    .raddr (ls_raddr),
    .rdata (ls_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
      rcnt    <= '0;
    end else begin
      rd_pend <= ls_re;
      rcnt    <= ls_re ? rcnt + 2'd1 : 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    rd_tag <= rcnt;
    if (rd_pend) begin
      col_new[rd_tag] <= ls_rdata;
    end
  end

  // new column: four stored rows, then the incoming pair at the bottom
  always_comb begin
    for (int j = 0; j < 4; j++) begin
      new_pair[j] = col_new[j];
    end
    new_pair[4] = {pix_a, pix_b};
  end

  // window chain: shift one column in, or rotate so each pair passes cell 0
  for (genvar i = 0; i < WIN_N; i++) begin : g_cell
    always_comb begin
      cctrl[i].en       = (state == S_SHIFT) || (state == S_SUM) ||
                          ((state == S_DEV) && (k < 5'(WIN_N)));
      cctrl[i].take_ext = (state == S_SHIFT) && ((i % 5) == 4);
    end
    wsm_cell u_cell (
      .clk  (clk),
      .ctrl (cctrl[i]),
      .nbr  (pairs[(i + 1) % WIN_N]),
      .ext  (new_pair[i / 5]),
      .pair (pairs[i])
    );
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    case (state)
      S_IDLE:   if (in_acc) state_next = S_READ;
      S_READ:   if (rcnt == 2'd3) state_next = S_WRITE;
      S_WRITE:  state_next = S_SHIFT;
      S_SHIFT:  state_next = emit_q ? S_SUM : S_IDLE;
      S_SUM:    if (k == 5'(WIN_N - 1)) state_next = S_DEV;
      S_DEV:    if (k == 5'(WIN_N + 2)) state_next = S_MEANS;
      S_MEANS:  state_next = S_PREP;
      S_PREP:   state_next = S_ABS;
      S_ABS:    state_next = S_DSTART;
      S_DSTART: begin
        div_start  = 1'b1;
        state_next = S_DIV;
      end
      S_DIV:    if (!busy1 && !busy2) state_next = S_MUL;
      S_MUL:    state_next = S_ROUND;
      S_ROUND:  state_next = S_OUT;
      S_OUT:    if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      k <= '0;
    end else if ((state == S_SUM) && (k == 5'(WIN_N - 1))) begin
      k <= '0;
    end else if ((state == S_SUM) || (state == S_DEV)) begin
      k <= k + 5'd1;
    end else begin
      k <= '0;
    end
  end

  // sums of the window
  always_ff @(posedge clk) begin
    if (state == S_SHIFT) begin
      sx <= '0;
      sy <= '0;
    end else if (state == S_SUM) begin
      sx <= sx + 13'(pairs[0][15:8]);
      sy <= sy + 13'(pairs[0][7:0]);
    end
  end

  // weighted deviations: four-stage pipe fed from cell 0
  assign a25 = 13'({pairs[0][15:8], 4'b0000}) + 13'({pairs[0][15:8], 3'b000}) +
               13'(pairs[0][15:8]);
  assign b25 = 13'({pairs[0][7:0], 4'b0000}) + 13'({pairs[0][7:0], 3'b000}) +
               13'(pairs[0][7:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= (state == S_DEV) && (k < 5'(WIN_N));
      v2 <= v1;
      v3 <= v2;
    end
  end

  always_ff @(posedge clk) begin
    dx  <= $signed({1'b0, a25}) - $signed({1'b0, sx});
    dy  <= $signed({1'b0, b25}) - $signed({1'b0, sy});
    w1  <= (k < 5'(WIN_N)) ? weight[WSLOT[k]] : 16'd0;
    pxx <= dx * dx;
    pyy <= dy * dy;
    pxy <= dx * dy;
    w2  <= w1;
    txx <= pxx[25:0] * w2;
    tyy <= pyy[25:0] * w2;
    txy <= pxy * $signed({1'b0, w2});
  end

  always_ff @(posedge clk) begin
    if (state == S_SUM) begin
      fxx <= '0;
      fyy <= '0;
      fxy <= '0;
    end else if (v3) begin
      fxx <= fxx + 47'(txx);
      fyy <= fyy + 47'(tyy);
      fxy <= fxy + 48'(txy);
    end
  end

  // ratio terms
  always_ff @(posedge clk) begin
    if (state == S_MEANS) begin
      pss <= sx * sy;
      psx <= sx * sx;
      psy <= sy * sy;
    end
    if (state == S_PREP) begin
      n1 <= (DIV_W'(pss) << 5) + C1_SCALED;
      d1 <= ((DIV_W'(psx) + DIV_W'(psy)) << 4) + C1_SCALED;
      n2 <= (54'(fxy) <<< 5) + $signed({1'b0, C2_SCALED});
      d2 <= ((DIV_W'(fxx) + DIV_W'(fyy)) << 4) + C2_SCALED;
    end
    if (state == S_ABS) begin
      neg  <= n2[53];
      mag2 <= n2[53] ? DIV_W'(-n2) : DIV_W'(n2);
    end
  end

  wsm_frac u_frac1 (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (n1),
    .den   (d1),
    .q     (q1),
    .busy  (busy1)
  );

  wsm_frac u_frac2 (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (mag2),
    .den   (d2),
    .q     (q2),
    .busy  (busy2)
  );

  // product, round half away from zero to Q2.14, saturate
  assign rsum  = prod + (62'd1 << 45);
  assign mag16 = rsum[61:46];
  assign val17 = neg ? -$signed({1'b0, mag16}) : $signed({1'b0, mag16});

  always_ff @(posedge clk) begin
    if (state == S_MUL) begin
      prod <= q1 * q2;
    end
    if (state == S_ROUND) begin
      if (val17 > 17'sd32767) begin
        res16 <= 16'sh7fff;
      end else if (val17 < -17'sd32768) begin
        res16 <= 16'sh8000;
      end else begin
        res16 <= 16'(val17);
      end
    end
  end

  // output register: hold the beat until the receiver takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((state == S_OUT) && (!out_valid || out_ready)) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state == S_OUT) && (!out_valid || out_ready)) begin
      ssim_value    <= res16;
      last_of_frame <= last_q;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/wsm_checker.sv -----
// ----------------------------------------------------------------------------
// wsm_checker
// Port-level checks of the SSIM map unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "windowed_ssim_map_unit_defines.svh"

module wsm_checker (
  input wire logic               clk,
  input wire logic               rst,
  input wire logic               in_valid,
  input wire logic               in_ready,
  input wire logic               out_valid,
  input wire logic               out_ready,
  input wire logic signed [15:0] ssim_value,
  input wire logic               last_of_frame
);

  // a stalled output beat holds
  `WSM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(ssim_value) && $stable(last_of_frame), "output beat changed while stalled")

  // an accepted pixel always occupies the block for a while
  `WSM_ASSERT_NEXT(a_busy_after_accept, in_valid && in_ready, !in_ready, "ready right after an accepted pixel")

  // both ratios lie within -1..1, so the result stays within one in Q2.14
  `WSM_ASSERT_NOW(a_ssim_range, out_valid, (ssim_value <= 16'sd16384) && (ssim_value >= -16'sd16384), "SSIM value outside -1..1")

endmodule

bind windowed_ssim_map_unit wsm_checker u_wsm_checker (.*);

`default_nettype wire
